### sv/ipap_pkg.sv
// ipap_pkg: shared types, character codes and per-character step functions
// for the address text parser. No dependencies.
`default_nettype none
package ipap_pkg;

	localparam int unsigned NUM_GROUPS = 8;
	localparam int unsigned NUM_OCTETS = 4;
	localparam logic [3:0] NO_GAP = 4'd8;
	localparam logic [9:0] DEC_SAT = 10'd1023;
	localparam logic [9:0] PART_MAX = 10'd255;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_F = 8'h66;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [1:0] FAM_V4 = 2'd0;
	localparam logic [1:0] FAM_V6 = 2'd1;

	typedef enum logic [1:0] {
		ST_PARSED = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_V4 = 3'd1,
		PH_V6_LEAD = 3'd2,
		PH_V6_TOP = 3'd3,
		PH_V6_GAP = 3'd4,
		PH_V6_GROUP = 3'd5,
		PH_DRAIN = 3'd6,
		PH_V4_TAIL = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [NUM_GROUPS-1:0][15:0] groups;
		logic [2:0] gi;
		logic [3:0] gap;
		logic [2:0] dc;
		logic [15:0] hex;
		logic [9:0] dec;
		logic [NUM_OCTETS-1:0][7:0] octets;
		logic [1:0] oi;
		logic err;
	} pstate_t;

	// end-of-string data handed to the address assembly
	typedef struct packed {
		logic ok;
		logic v6;
		logic tail;
		status_t status;
		logic [NUM_GROUPS-1:0][15:0] groups;
		logic [2:0] last;
		logic [3:0] gap;
		logic [31:0] v4_word;
	} eos_t;

	localparam pstate_t PSTATE_RESET = '{
		phase: PH_START, groups: '0, gi: 3'd0, gap: NO_GAP, dc: 3'd0,
		hex: 16'd0, dec: 10'd0, octets: '0, oi: 2'd0, err: 1'b0
	};

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [7:0] lc;
		lc = c | CASE_BIT;
		if (is_dec(c)) begin
			return {1'b1, 4'(c - CH_ZERO)};
		end
		if (lc >= CH_LC_A && lc <= CH_LC_F) begin
			return {1'b1, 4'(lc - CH_LC_A + 8'd10)};
		end
		return 5'd0;
	endfunction

	function automatic logic [9:0] dec_push(logic [9:0] acc, logic [3:0] d);
		logic [13:0] v;
		v = 14'(acc) * 14'd10 + 14'(d);
		return (v > 14'(DEC_SAT)) ? DEC_SAT : v[9:0];
	endfunction

	function automatic logic part_ok(pstate_t s);
		if (s.dc < 3'd1 || s.dc > 3'd3) return 1'b0;
		if (s.dec > PART_MAX) return 1'b0;
		if (s.dc == 3'd2 && s.dec < 10'd10) return 1'b0;
		if (s.dc == 3'd3 && s.dec < 10'd100) return 1'b0;
		return 1'b1;
	endfunction

	function automatic pstate_t fail_st(pstate_t s);
		pstate_t r;
		r = s;
		r.phase = PH_DRAIN;
		r.err = 1'b1;
		return r;
	endfunction

	function automatic pstate_t v6_top(pstate_t s, logic [7:0] c);
		pstate_t r;
		logic [4:0] hv;
		r = s;
		hv = hex_val(c);
		if (c == CH_COLON && s.gap == NO_GAP) begin
			r.gap = {1'b0, s.gi};
			r.groups[s.gi] = 16'd0;
			r.phase = PH_V6_GAP;
		end else if (!hv[4]) begin
			r = fail_st(s);
		end else begin
			r.hex = 16'(hv[3:0]);
			r.dec = (hv[3:0] < 4'd10) ? 10'(hv[3:0]) : DEC_SAT;
			r.dc = 3'd1;
			r.phase = PH_V6_GROUP;
		end
		return r;
	endfunction

	function automatic pstate_t v4_char(pstate_t s, logic [7:0] c);
		pstate_t r;
		r = s;
		if (is_dec(c)) begin
			if (s.dc >= 3'd3) begin
				r = fail_st(s);
			end else begin
				r.dec = dec_push(s.dec, 4'(c - CH_ZERO));
				r.dc = s.dc + 3'd1;
			end
		end else if (c != CH_DOT || !part_ok(s) || s.oi == 2'd3) begin
			r = fail_st(s);
		end else begin
			r.octets[s.oi] = s.dec[7:0];
			r.oi = s.oi + 2'd1;
			r.dc = 3'd0;
			r.dec = 10'd0;
		end
		return r;
	endfunction

	function automatic pstate_t group_char(pstate_t s, logic [7:0] c);
		pstate_t r;
		logic [4:0] hv;
		r = s;
		hv = hex_val(c);
		if (hv[4]) begin
			if (s.dc >= 3'd4) begin
				r = fail_st(s);
			end else begin
				r.hex = {s.hex[11:0], hv[3:0]};
				r.dec = (hv[3:0] < 4'd10) ? dec_push(s.dec, hv[3:0]) : DEC_SAT;
				r.dc = s.dc + 3'd1;
			end
		end else begin
			r.groups[s.gi] = s.hex;
			if (s.gi == 3'd7) begin
				r = fail_st(r);
			end else if (c == CH_COLON) begin
				r.gi = s.gi + 3'd1;
				r.dc = 3'd0;
				r.hex = 16'd0;
				r.dec = 10'd0;
				r.phase = PH_V6_TOP;
			end else if (c == CH_DOT) begin
				if ((s.gi < 3'd6 && s.gap == NO_GAP) || !part_ok(s)) begin
					r = fail_st(r);
				end else begin
					r.gi = s.gi + 3'd1;
					r.groups[s.gi + 3'd1] = 16'd0;
					r.octets[0] = s.dec[7:0];
					r.oi = 2'd1;
					r.dc = 3'd0;
					r.dec = 10'd0;
					r.phase = PH_V4_TAIL;
				end
			end else begin
				r = fail_st(r);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/ipap_step.sv
// ipap_step: next parse state for one character, and the end-of-string
// decision when the character is NUL. Uses ipap_pkg.
`default_nettype none
module ipap_step
	import ipap_pkg::*;
(
	input  pstate_t    cur,
	input  logic [7:0] ch,
	input  logic [1:0] family,
	output pstate_t    nxt,
	output eos_t       eos
);

	pstate_t fin;

	always_comb begin
		nxt = cur;
		fin = cur;
		unique case (cur.phase)
			PH_START: begin
				if (family == FAM_V4) begin
					fin.phase = PH_V4;
					nxt = v4_char(fin, ch);
				end else if (family == FAM_V6) begin
					if (ch == CH_COLON) nxt.phase = PH_V6_LEAD;
					else nxt = v6_top(cur, ch);
				end else begin
					nxt.phase = PH_DRAIN;
					nxt.err = 1'b0;
				end
			end
			PH_V4, PH_V4_TAIL: nxt = v4_char(cur, ch);
			PH_V6_LEAD: begin
				if (ch == CH_COLON) nxt = v6_top(cur, ch);
				else nxt = fail_st(cur);
			end
			PH_V6_TOP: nxt = v6_top(cur, ch);
			PH_V6_GAP: begin
				if (cur.gi == 3'd7) begin
					nxt = fail_st(cur);
				end else begin
					fin.gi = cur.gi + 3'd1;
					nxt = v6_top(fin, ch);
				end
			end
			PH_V6_GROUP: nxt = group_char(cur, ch);
			PH_DRAIN: nxt = cur;
		endcase
		if (ch == CH_NUL) nxt = PSTATE_RESET;
	end

	// end of string: pending group or octet is folded in here
	always_comb begin
		logic [NUM_GROUPS-1:0][15:0] g;
		logic [NUM_OCTETS-1:0][7:0] o;
		g = cur.groups;
		o = cur.octets;
		eos.ok = 1'b0;
		eos.v6 = 1'b0;
		eos.tail = 1'b0;
		eos.status = ST_MALFORMED;
		unique case (cur.phase)
			PH_START: eos.status = (family >= 2'd2) ? ST_UNSUPPORTED : ST_MALFORMED;
			PH_DRAIN: eos.status = cur.err ? ST_MALFORMED : ST_UNSUPPORTED;
			PH_V4, PH_V4_TAIL: begin
				if (part_ok(cur) && cur.oi == 2'd3) begin
					o[3] = cur.dec[7:0];
					eos.ok = 1'b1;
					eos.tail = (cur.phase == PH_V4_TAIL);
					eos.v6 = (cur.phase == PH_V4_TAIL);
				end
			end
			PH_V6_GAP: begin
				eos.ok = 1'b1;
				eos.v6 = 1'b1;
			end
			PH_V6_GROUP: begin
				g[cur.gi] = cur.hex;
				if (cur.gap != NO_GAP || cur.gi == 3'd7) begin
					eos.ok = 1'b1;
					eos.v6 = 1'b1;
				end
			end
			PH_V6_LEAD, PH_V6_TOP: eos.status = ST_MALFORMED;
		endcase
		eos.groups = g;
		eos.last = cur.gi;
		eos.gap = cur.gap;
		eos.v4_word = {o[0], o[1], o[2], o[3]};
	end

endmodule
`default_nettype wire

### sv/ipap_expand.sv
// ipap_expand: builds the final status and 128-bit address from the
// end-of-string data, zero-filling the '::' gap. Uses ipap_pkg.
`default_nettype none
module ipap_expand
	import ipap_pkg::*;
(
	input  eos_t        eos,
	output logic [1:0]  status,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	logic [NUM_GROUPS-1:0][15:0] r;
	logic [2:0] shift;
	logic       has_gap;

	assign has_gap = (eos.gap < NO_GAP) && (eos.gap <= {1'b0, eos.last});
	assign shift = 3'd7 - eos.last;

	// groups after the gap slide right by the number of missing groups
	always_comb begin
		for (int j = 0; j < NUM_GROUPS; j++) begin
			if (!has_gap || 4'(j) < eos.gap) r[j] = eos.groups[j];
			else if (4'(j) < eos.gap + 4'(shift)) r[j] = 16'd0;
			else r[j] = eos.groups[3'(j) - shift];
		end
	end

	always_comb begin
		status = ST_MALFORMED;
		addr_high = 64'd0;
		addr_low = 64'd0;
		if (!eos.ok) begin
			status = eos.status;
		end else if (eos.v6) begin
			status = ST_PARSED;
			addr_high = {r[0], r[1], r[2], r[3]};
			addr_low = {r[4], r[5], r[6], r[7]};
			if (eos.tail) addr_low[31:0] = eos.v4_word;
		end else begin
			status = ST_PARSED;
			addr_low = {32'd0, eos.v4_word};
		end
	end

endmodule
`default_nettype wire

### sv/ip_address_text_parser_core.sv
// ip_address_text_parser_core: top level, input register, parse state and
// result register. Uses ipap_pkg, ipap_step and ipap_expand.
`default_nettype none
// The text arrives one character per item with its family code; only the NUL
// item produces a result (status plus the 128-bit address), which is written
// to the result register when that NUL leaves the input register. The block
// takes one character per cycle: each item waits in the input register while
// the parse state and, for NUL, the result register are updated from it. Only
// a held result slows it down: a NUL cannot leave the input register while the
// result register holds an item that is not being taken.
module ip_address_text_parser_core
	import ipap_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic [1:0]  family,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [63:0]      addr_high,
	output logic [63:0]      addr_low
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic [1:0]  family_s1;
	pstate_t     st_q;
	pstate_t     st_nxt;
	eos_t        eos;
	logic        is_nul;
	logic        fire_s1;
	logic [1:0]  status_nxt;
	logic [63:0] high_nxt;
	logic [63:0] low_nxt;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [63:0] high_q;
	logic [63:0] low_q;

	ipap_step u_step (
		.cur    (st_q),
		.ch     (ch_s1),
		.family (family_s1),
		.nxt    (st_nxt),
		.eos    (eos)
	);

	ipap_expand u_expand (
		.eos       (eos),
		.status    (status_nxt),
		.addr_high (high_nxt),
		.addr_low  (low_nxt)
	);

	assign is_nul = (ch_s1 == CH_NUL);
	assign fire_s1 = valid_s1 && (!is_nul || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= PSTATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (fire_s1) st_q <= st_nxt;
			if (fire_s1 && is_nul) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= ch;
			family_s1 <= family;
		end
		if (fire_s1 && is_nul) begin
			status_q <= status_nxt;
			high_q <= high_nxt;
			low_q <= low_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign addr_high = high_q;
	assign addr_low = low_q;

endmodule
`default_nettype wire
